/* rtl/multi_frame_packet_assembler_core_macros.svh */
// Assertion macros used by the packet assembler checker
`ifndef MULTI_FRAME_PACKET_ASSEMBLER_CORE_MACROS_SVH
`define MULTI_FRAME_PACKET_ASSEMBLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low
`define MFPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low
`define MFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mfpa_pkg.sv */
// Types and constants of the multi-frame packet assembler
package mfpa_pkg;

    localparam int HDR_W     = 16;
    localparam int ID_W      = 32;
    localparam int TIME_W    = 48;
    localparam int CNT_W     = 32;
    localparam int FIP_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int N_DROP    = 4;
    localparam int DROP_W    = 2;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_DISABLED    = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_COUNT   = 3'd3,
        ST_BAD_NUMBER  = 3'd4,
        ST_BAD_ID      = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_FRAMES  = 2'd2,
        CFG_DATA_ID = 2'd3
    } t_cfg_idx;

    typedef enum logic [DROP_W-1:0] {
        DROP_VERSION = 2'd0,
        DROP_COUNT   = 2'd1,
        DROP_NUMBER  = 2'd2,
        DROP_ID      = 2'd3
    } t_drop_idx;

    typedef struct packed {
        logic              enable;
        logic [HDR_W-1:0]  version;
        logic [FIP_W-1:0]  frames;
        logic [ID_W-1:0]   data_id;
    } t_cfg;

    // Classified frame, as handed from the front end to the back end
    typedef struct packed {
        t_status           status;
        logic [HDR_W-1:0]  frame_number;
        logic [HDR_W-1:0]  numerator;
        logic              present;
        logic [TIME_W-1:0] arrival_time;
        logic              sim;
    } t_work;

endpackage

/* rtl/mfpa_if.sv */
// Valid/ready channel interfaces for frame headers and assembly results
interface mfpa_in_if import mfpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HDR_W-1:0]  hdr_version;
    logic [HDR_W-1:0]  hdr_frame_count;
    logic [HDR_W-1:0]  frame_number;
    logic [ID_W-1:0]   data_id;
    logic [HDR_W-1:0]  packet_numerator;
    logic [HDR_W-1:0]  frame_size;
    logic [TIME_W-1:0] arrival_time;
    logic              sim_frame;

    modport source (
        output valid, hdr_version, hdr_frame_count, frame_number, data_id,
               packet_numerator, frame_size, arrival_time, sim_frame,
        input  ready
    );
    modport sink (
        input  valid, hdr_version, hdr_frame_count, frame_number, data_id,
               packet_numerator, frame_size, arrival_time, sim_frame,
        output ready
    );
endinterface

interface mfpa_out_if import mfpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic              packet_complete;
    logic [TIME_W-1:0] packet_time;
    logic              packet_is_sim;
    logic [CNT_W-1:0]  error_total;

    modport source (
        output valid, status, packet_complete, packet_time, packet_is_sim, error_total,
        input  ready
    );
    modport sink (
        input  valid, status, packet_complete, packet_time, packet_is_sim, error_total,
        output ready
    );
endinterface

/* rtl/multi_frame_packet_assembler_core.sv */
// Multi-frame packet assembler: top level with configuration registers
//
// Channels: i_in carries one frame header per transfer, o_out one result per
// frame, both valid/ready. Every input transfer gives exactly one result, in
// order; dropped frames give a status code and packet_complete low.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one register per cycle;
// write only while no frame is in flight. Writing frames_in_packet clears
// all slots; the value is held clamped to 1..MAX_FRAMES.
// Path: an input transfer goes through the front register, the queue and the
// result register, in that order. Throughput: one frame per cycle while o_out
// is not stalled; the back end updates the slot register file for each frame.
// Reset (i_rst_n low, synchronous): registers return to their defaults,
// slots, packet time, flags and counters go to zero; no clearing pass.
// Stall: a held result keeps o_out steady; the two-entry queue and the
// front register absorb up to three more frames before i_in.ready drops.
// error_total is the saturated sum of the four drop counters.
module multi_frame_packet_assembler_core import mfpa_pkg::*; #(
    parameter int MAX_FRAMES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    mfpa_in_if.sink              i_in,
    mfpa_out_if.source           o_out
);

    t_cfg             r_cfg;
    logic             slot_clr;
    logic [FIP_W-1:0] frames_wr;

    logic  f_vld;
    t_work f_work;
    logic  f_rdy;
    logic  q_vld;
    t_work q_work;
    logic  q_rdy;

    // frames_in_packet held within 1..MAX_FRAMES
    always_comb begin
        frames_wr = i_cfg_data[FIP_W-1:0];
        if (frames_wr == '0) begin
            frames_wr = FIP_W'(1);
        end else if (int'(frames_wr) > MAX_FRAMES) begin
            frames_wr = FIP_W'(MAX_FRAMES);
        end
    end

    assign slot_clr = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_FRAMES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable  <= 1'b0;
            r_cfg.version <= '0;
            r_cfg.frames  <= FIP_W'(1);
            r_cfg.data_id <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:  r_cfg.enable  <= i_cfg_data[0];
                CFG_VERSION: r_cfg.version <= i_cfg_data[HDR_W-1:0];
                CFG_FRAMES:  r_cfg.frames  <= frames_wr;
                CFG_DATA_ID: r_cfg.data_id <= i_cfg_data[ID_W-1:0];
                default:     r_cfg.enable  <= r_cfg.enable;
            endcase
        end
    end

    mfpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_vld   (f_vld),
        .o_work  (f_work),
        .i_rdy   (f_rdy)
    );

    mfpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_work  (f_work),
        .o_rdy   (f_rdy),
        .o_vld   (q_vld),
        .o_work  (q_work),
        .i_rdy   (q_rdy)
    );

    mfpa_back #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frames   (r_cfg.frames),
        .i_slot_clr (slot_clr),
        .i_vld      (q_vld),
        .i_work     (q_work),
        .o_rdy      (q_rdy),
        .o_out      (o_out)
    );

endmodule

/* rtl/mfpa_front.sv */
// Front end: takes frame headers, runs the drop checks, registers the verdict
module mfpa_front import mfpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    mfpa_in_if.sink  i_in,
    output logic     o_vld,
    output t_work    o_work,
    input  logic     i_rdy
);

    logic    r_vld;
    t_work   r_work;
    t_status status;
    logic [HDR_W-1:0] frames_ext;

    assign frames_ext = {{(HDR_W-FIP_W){1'b0}}, i_cfg.frames};
    assign i_in.ready = !r_vld || i_rdy;

    // Checks in priority order; first failure wins
    always_comb begin
        if (!i_cfg.enable) begin
            status = ST_DISABLED;
        end else if (i_in.hdr_version != i_cfg.version) begin
            status = ST_BAD_VERSION;
        end else if (i_in.hdr_frame_count != frames_ext) begin
            status = ST_BAD_COUNT;
        end else if (i_in.frame_number >= frames_ext) begin
            status = ST_BAD_NUMBER;
        end else if (i_in.data_id != i_cfg.data_id) begin
            status = ST_BAD_ID;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_work.status       <= status;
            r_work.frame_number <= i_in.frame_number;
            r_work.numerator    <= i_in.packet_numerator;
            r_work.present      <= (i_in.frame_size != '0);
            r_work.arrival_time <= i_in.arrival_time;
            r_work.sim          <= i_in.sim_frame;
        end
    end

    assign o_vld  = r_vld;
    assign o_work = r_work;

endmodule

/* rtl/mfpa_queue.sv */
// Two-entry queue between front and back end
module mfpa_queue import mfpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_work i_work,
    output logic  o_rdy,
    output logic  o_vld,
    output t_work o_work,
    input  logic  i_rdy
);

    t_work              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QPTR_W:0]    r_cnt;
    logic               push;
    logic               pop;

    assign o_rdy  = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_vld  = (r_cnt != '0);
    assign push   = i_vld && o_rdy;
    assign pop    = o_vld && i_rdy;
    assign o_work = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

/* rtl/mfpa_back.sv */
// Back end: slot file, packet time, drop counters and the result register
module mfpa_back import mfpa_pkg::*; #(
    parameter int MAX_FRAMES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [FIP_W-1:0] i_frames,
    input  logic             i_slot_clr,
    input  logic             i_vld,
    input  t_work            i_work,
    output logic             o_rdy,
    mfpa_out_if.source       o_out
);

    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [MAX_FRAMES-1:0] r_present;
    logic [HDR_W-1:0]      r_num [MAX_FRAMES];
    logic [TIME_W-1:0]     r_time;
    logic                  r_sim;
    logic [CNT_W-1:0]      r_drop [N_DROP];
    logic [CNT_W-1:0]      r_total;

    logic                  r_out_vld;
    t_status               r_o_status;
    logic                  r_o_complete;
    logic [TIME_W-1:0]     r_o_time;
    logic                  r_o_sim;
    logic [CNT_W-1:0]      r_o_total;

    logic                  n_out_vld;
    logic [MAX_FRAMES-1:0] n_present;
    logic [TIME_W-1:0]     n_time;
    logic                  n_sim;
    logic [CNT_W-1:0]      n_total;

    logic                  go;
    logic                  ok;
    logic [SLOT_W-1:0]     fidx;
    logic [MAX_FRAMES-1:0] mask;
    logic [MAX_FRAMES-1:0] match;
    logic                  complete;
    logic [TIME_W-1:0]     t_raised;
    logic                  drop;
    t_drop_idx             drop_k;
    logic                  drop_inc;

    assign go    = i_vld && (!r_out_vld || o_out.ready);
    assign o_rdy = go;
    assign ok    = (i_work.status == ST_OK);
    assign fidx  = i_work.frame_number[SLOT_W-1:0];

    // Slot compare with this frame already written into its slot
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            mask[i] = (int'(i_frames) > i);
            if (i == int'(fidx)) begin
                match[i] = i_work.present;
            end else begin
                match[i] = r_present[i] && (r_num[i] == i_work.numerator);
            end
        end
        complete = (i_frames == FIP_W'(1)) || (&(match | ~mask));
    end

    // Packet time strictly rises, pinned at the top of the range
    assign t_raised = (i_work.arrival_time > r_time) ? i_work.arrival_time :
                      (r_time == TIME_MAX) ? TIME_MAX : r_time + TIME_W'(1);

    always_comb begin
        drop   = 1'b1;
        drop_k = DROP_VERSION;
        case (i_work.status)
            ST_BAD_VERSION: drop_k = DROP_VERSION;
            ST_BAD_COUNT:   drop_k = DROP_COUNT;
            ST_BAD_NUMBER:  drop_k = DROP_NUMBER;
            ST_BAD_ID:      drop_k = DROP_ID;
            default:        drop   = 1'b0;
        endcase
        drop_inc = drop && (r_drop[drop_k] != CNT_MAX);
    end

    // Running saturated sum of the drop counters
    assign n_total = (drop_inc && (r_total != CNT_MAX)) ? r_total + CNT_W'(1) : r_total;

    always_comb begin
        n_present = r_present;
        n_time    = r_time;
        n_sim     = r_sim;
        if (ok) begin
            n_present[fidx] = i_work.present;
            if (i_work.frame_number == '0) begin
                n_time = t_raised;
                n_sim  = i_work.sim;
            end else begin
                n_sim  = r_sim | i_work.sim;
            end
            if (complete) begin
                n_present = '0;
            end
        end
    end

    always_comb begin
        if (go) begin
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_time    <= '0;
            r_sim     <= 1'b0;
            r_drop    <= '{default: '0};
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            if (i_slot_clr) begin
                r_present <= '0;
            end else if (go) begin
                r_present <= n_present;
            end
            if (go) begin
                r_time  <= n_time;
                r_sim   <= n_sim;
                r_total <= n_total;
                if (drop_inc) begin
                    r_drop[drop_k] <= r_drop[drop_k] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && ok) begin
            r_num[fidx] <= i_work.numerator;
        end
        if (go) begin
            r_o_status   <= i_work.status;
            r_o_complete <= ok && complete;
            r_o_time     <= n_time;
            r_o_sim      <= n_sim;
            r_o_total    <= n_total;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.status          = r_o_status;
    assign o_out.packet_complete = r_o_complete;
    assign o_out.packet_time     = r_o_time;
    assign o_out.packet_is_sim   = r_o_sim;
    assign o_out.error_total     = r_o_total;

endmodule

/* rtl/mfpa_checker.sv */
// Port-level checks on the assembler result channel, bound to the top level
`include "multi_frame_packet_assembler_core_macros.svh"

module mfpa_checker import mfpa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [2:0]        i_status,
    input logic              i_complete,
    input logic [TIME_W-1:0] i_time,
    input logic [CNT_W-1:0]  i_total
);

    logic [TIME_W-1:0] r_last_time;
    logic [CNT_W-1:0]  r_last_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_last_total <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_time  <= i_time;
            r_last_total <= i_total;
        end
    end

    `MFPA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `MFPA_ASSERT_NOW(a_complete_ok, i_out_valid && i_complete, i_status == ST_OK, "dropped frame completed a packet")
    `MFPA_ASSERT_NOW(a_status_code, i_out_valid, i_status <= ST_BAD_ID, "status code out of range")
    `MFPA_ASSERT_NOW(a_time_mono, i_out_valid, i_time >= r_last_time, "packet time went backwards")
    `MFPA_ASSERT_NOW(a_total_mono, i_out_valid, i_total >= r_last_total, "error total went backwards")

endmodule

bind multi_frame_packet_assembler_core mfpa_checker u_mfpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_complete  (o_out.packet_complete),
    .i_time      (o_out.packet_time),
    .i_total     (o_out.error_total)
);
